FILE: hdl/tbpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbpm_pkg: shared definitions for the time binned packet metric counter
// Field widths, register indexes, status codes, control structs and the
// per-metric increment table.
// ----------------------------------------------------------------------------
package tbpm_pkg;

    // default store geometry
    localparam int DEF_NUM_BINS    = 1024;
    localparam int DEF_NUM_METRICS = 7;
    localparam int DEF_COUNT_WIDTH = 48;

    // field widths
    localparam int SEC_W    = 32;
    localparam int USEC_W   = 20;
    localparam int WIDTH_W  = 32;
    localparam int BINS_W   = 11;
    localparam int MEN_W    = 7;
    localparam int LEN_W    = 16;
    localparam int FLAG_W   = 8;
    localparam int RBIN_W   = 10;
    localparam int RMET_W   = 3;
    localparam int STAT_W   = 2;
    localparam int VALUE_W  = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 64;

    // offset arithmetic
    localparam int           PROD_W       = 54;  // signed offset in microseconds
    localparam int           MAG_W        = 54;  // magnitude of the offset
    localparam int           QUOT_W       = BINS_W;  // bin index never needs more
    localparam int           REM_W        = WIDTH_W + QUOT_W;
    localparam int           IDX_WIDE_W   = 17;  // holds any NUM_BINS value
    localparam int           USEC_PER_SEC = 1000000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECONDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MICROS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_METRIC_ENABLE = 3'd4;

    // request kinds
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_METRIC = 2'd2;

    // metric numbers
    localparam logic [RMET_W-1:0] MET_PACKETS = 3'd0;
    localparam logic [RMET_W-1:0] MET_BYTES   = 3'd1;
    localparam logic [RMET_W-1:0] MET_SYN     = 3'd2;
    localparam logic [RMET_W-1:0] MET_FIN     = 3'd3;
    localparam logic [RMET_W-1:0] MET_RST     = 3'd4;
    localparam logic [RMET_W-1:0] MET_ACK     = 3'd5;
    localparam logic [RMET_W-1:0] MET_PSH     = 3'd6;

    // TCP flag bit positions
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_PSH = 3;
    localparam int FLAG_ACK = 4;

    typedef struct packed {
        logic start;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quotient;
    } div_res_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_cmd_t;

    typedef struct packed {
        logic clear_busy;
    } store_stat_t;

    // increment that one packet adds to a metric
    function automatic logic [LEN_W-1:0] metric_amount(
        input logic [RMET_W-1:0] met,
        input logic [LEN_W-1:0]  len,
        input logic [FLAG_W-1:0] flags
    );
        logic [LEN_W-1:0] amt;
        case (met)
            MET_PACKETS: amt = LEN_W'(1);
            MET_BYTES:   amt = len;
            MET_SYN:     amt = LEN_W'(flags[FLAG_SYN]);
            MET_FIN:     amt = LEN_W'(flags[FLAG_FIN]);
            MET_RST:     amt = LEN_W'(flags[FLAG_RST]);
            MET_ACK:     amt = LEN_W'(flags[FLAG_ACK]);
            MET_PSH:     amt = LEN_W'(flags[FLAG_PSH]);
            default:     amt = '0;
        endcase
        return amt;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/tbpm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbpm_div: bin index divider
// Restoring divider, one quotient bit per cycle. Dividends whose quotient
// would not fit QUOT_W bits are flagged up front; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module tbpm_div (
    input  wire                       clk,
    input  wire                       rst_n,
    input  tbpm_pkg::div_cmd_t        cmd,
    input  wire [tbpm_pkg::MAG_W-1:0] dividend,
    input  wire [tbpm_pkg::WIDTH_W-1:0] divisor,
    output tbpm_pkg::div_res_t        res
);
    import tbpm_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  dsh_reg, dsh_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              ovf_reg, ovf_next;

    logic [REM_W-1:0] top_limit;
    logic             too_big;
    logic             fits;

    assign top_limit = {divisor, {QUOT_W{1'b0}}};
    assign too_big   = dividend >= MAG_W'(top_limit);
    assign fits      = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        if (cmd.start)
        begin
            q_next    = '0;
            step_next = '0;
            ovf_next  = 1'b0;
            if (divisor == '0)
            begin
                done_next = 1'b1;
            end
            else if (too_big)
            begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = dividend[REM_W-1:0];
                dsh_next  = REM_W'(divisor) << (QUOT_W - 1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next    = {q_reg[QUOT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign res.done     = done_reg;
    assign res.ovf      = ovf_reg;
    assign res.quotient = q_reg;

endmodule
`default_nettype wire

FILE: hdl/tbpm_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbpm_store: counter memory with saturating update
// One memory of all counters, addressed {metric, bin}. A write stores the
// last read value plus an increment, clamped at full scale. After reset a
// clearing pass writes zero to every entry, one per cycle.
// ----------------------------------------------------------------------------
module tbpm_store #(
    parameter int NUM_BINS    = tbpm_pkg::DEF_NUM_BINS,
    parameter int NUM_METRICS = tbpm_pkg::DEF_NUM_METRICS,
    parameter int COUNT_WIDTH = tbpm_pkg::DEF_COUNT_WIDTH,
    localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
    localparam int MET_W  = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1,
    localparam int ADDR_W = MET_W + BIN_W
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  tbpm_pkg::store_cmd_t       cmd,
    input  wire [ADDR_W-1:0]           addr,
    input  wire [tbpm_pkg::LEN_W-1:0]  amount,
    output logic [COUNT_WIDTH-1:0]     rd_data,
    output tbpm_pkg::store_stat_t      stat
);
    import tbpm_pkg::*;

    localparam int DEPTH = NUM_METRICS * (2 ** BIN_W);

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                   clr_busy_reg, clr_busy_next;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sat_value;

    // saturating add on the value read just before
    assign sum       = {1'b0, rd_data_reg} + (COUNT_WIDTH + 1)'(amount);
    assign sat_value = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.wr_en)
        begin
            mem[addr] <= sat_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data         = rd_data_reg;
    assign stat.clear_busy = clr_busy_reg;

endmodule
`default_nettype wire

FILE: hdl/time_binned_packet_metric_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_binned_packet_metric_counter: per-time-bin packet statistics
// Bins packets by timestamp and keeps saturating packet, byte and TCP flag
// counters per bin; read requests return one counter.
// ----------------------------------------------------------------------------
// One item at a time. A record item first forms the offset in S_MUL and
// S_OFS (one 33x21 multiply into a register, then the add). The divider
// finishes without iterating when the quotient is out of reach or the bin
// width is zero, and otherwise works one quotient bit per cycle, QUOT_W bits.
// Each enabled metric then takes a read and a write (the read-modify-write
// on the single counter memory port), disabled ones are skipped, and the
// result is handed to the output register. A record with no metric enabled
// goes straight to that hand-off. After reset the counter memory is cleared
// one entry per cycle, NUM_METRICS * 2^ceil(log2(NUM_BINS)) entries (7168 at
// the defaults); s_tready stays low until then, configuration writes are
// taken throughout. A finished result waits in the output register while
// the next item is accepted.
// ----------------------------------------------------------------------------
module time_binned_packet_metric_counter #(
    parameter int NUM_BINS    = tbpm_pkg::DEF_NUM_BINS,
    parameter int NUM_METRICS = tbpm_pkg::DEF_NUM_METRICS,
    parameter int COUNT_WIDTH = tbpm_pkg::DEF_COUNT_WIDTH
) (
    input  wire                             clk,
    input  wire                             rst_n,
    // configuration write port
    input  wire                             cfg_we,
    input  wire [tbpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [tbpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request stream
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // ts_seconds[31:0], ts_micros[51:32], packet_length[67:52],
    // tcp_flag_bits[75:68], read_bin[85:76], read_metric[88:86], zero pad
    input  wire [tbpm_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type[0]
    input  wire [0:0]                       s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // status[1:0], bin_index[11:2], read_value[59:12], zero pad
    output logic [tbpm_pkg::M_DATA_W-1:0]   m_tdata
);
    import tbpm_pkg::*;

    localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int MET_W  = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
    localparam int ADDR_W = MET_W + BIN_W;
    localparam logic [MEN_W-1:0] EN_MASK = MEN_W'((1 << NUM_METRICS) - 1);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_MUL     = 10'b0000000010,
        S_OFS     = 10'b0000000100,
        S_DIV     = 10'b0000001000,
        S_UPD_RD  = 10'b0000010000,
        S_UPD_WR  = 10'b0000100000,
        S_RD_ISS  = 10'b0001000000,
        S_RD_DATA = 10'b0010000000,
        S_DONE    = 10'b0100000000,
        S_SPARE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [SEC_W-1:0]   start_sec_reg;
    logic [USEC_W-1:0]  start_us_reg;
    logic [WIDTH_W-1:0] bin_width_reg;
    logic [BINS_W-1:0]  bins_use_reg;
    logic [MEN_W-1:0]   metric_en_reg;

    // captured item
    logic [SEC_W-1:0]  ts_s_reg;
    logic [USEC_W-1:0] ts_u_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [FLAG_W-1:0] flags_reg;
    logic [RBIN_W-1:0] rbin_reg;
    logic [RMET_W-1:0] rmet_reg;

    // offset and index
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg, neg_next;
    logic [QUOT_W-1:0]        bin_reg, bin_next;
    logic [RMET_W-1:0]        met_reg, met_next;

    // pending result and output register
    logic [STAT_W-1:0]  p_stat_reg, p_stat_next;
    logic [RBIN_W-1:0]  p_bin_reg, p_bin_next;
    logic [VALUE_W-1:0] p_val_reg, p_val_next;
    logic [STAT_W-1:0]  o_stat_reg;
    logic [RBIN_W-1:0]  o_bin_reg;
    logic [VALUE_W-1:0] o_val_reg;
    logic               m_valid_reg, m_valid_next;

    // datapath
    logic                     accept;
    logic [MEN_W-1:0]         en;
    logic signed [SEC_W:0]    sec_diff;
    logic signed [USEC_W:0]   usec_diff;
    logic signed [PROD_W-1:0] sec_us;
    logic signed [PROD_W-1:0] offset;
    logic [MAG_W-1:0]         magnitude;
    logic [IDX_WIDE_W-1:0]    limit;
    logic                     idx_out;
    logic                     rd_ok;
    logic                     out_load;
    logic                     last_met;
    logic [IDX_WIDE_W-1:0]    rec_bin_wide;
    logic [IDX_WIDE_W-1:0]    rd_bin_wide;
    logic [63:0]              rd_wide;

    div_cmd_t                 div_cmd;
    div_res_t                 div_res;
    store_cmd_t               st_cmd;
    store_stat_t              st_stat;
    logic [ADDR_W-1:0]        st_addr;
    logic [LEN_W-1:0]         st_amount;
    logic [COUNT_WIDTH-1:0]   st_rd_data;

    assign s_tready = (state_reg == S_IDLE) && !st_stat.clear_busy;
    assign accept   = s_tvalid && s_tready;
    assign en       = metric_en_reg & EN_MASK;

    // signed offset in microseconds from the start of bin zero
    assign sec_diff  = $signed({1'b0, ts_s_reg}) - $signed({1'b0, start_sec_reg});
    assign usec_diff = $signed({1'b0, ts_u_reg}) - $signed({1'b0, start_us_reg});
    // operands widen to the full product width before the multiply
    assign sec_us    = sec_diff * $signed((USEC_W + 1)'(USEC_PER_SEC));
    assign offset    = prod_reg + PROD_W'(usec_diff);
    assign magnitude = offset[PROD_W-1] ? MAG_W'(-offset) : MAG_W'(offset);

    // bins_in_use above the store size acts as the store size
    assign limit = (IDX_WIDE_W'(bins_use_reg) > IDX_WIDE_W'(NUM_BINS))
                 ? IDX_WIDE_W'(NUM_BINS) : IDX_WIDE_W'(bins_use_reg);

    // negative offsets within one bin width truncate into bin 0
    assign idx_out = div_res.ovf
                  || (neg_reg && (div_res.quotient != '0))
                  || (IDX_WIDE_W'(div_res.quotient) >= limit);

    assign rd_ok = (IDX_WIDE_W'(rbin_reg) < IDX_WIDE_W'(NUM_BINS))
                && ({1'b0, rmet_reg} < (RMET_W + 1)'(NUM_METRICS));

    assign last_met = met_reg == RMET_W'(NUM_METRICS - 1);
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    assign rec_bin_wide = IDX_WIDE_W'(bin_reg);
    assign rd_bin_wide  = IDX_WIDE_W'(rbin_reg);
    assign rd_wide      = 64'(st_rd_data);

    // counter memory address and increment
    always_comb
    begin
        if ((state_reg == S_RD_ISS) || (state_reg == S_RD_DATA))
        begin
            st_addr = {rmet_reg[MET_W-1:0], rd_bin_wide[BIN_W-1:0]};
        end
        else
        begin
            st_addr = {met_reg[MET_W-1:0], rec_bin_wide[BIN_W-1:0]};
        end
    end

    assign st_amount    = metric_amount(met_reg, len_reg, flags_reg);
    assign div_cmd.start = (state_reg == S_OFS);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        bin_next     = bin_reg;
        met_next     = met_reg;
        p_stat_next  = p_stat_reg;
        p_bin_next   = p_bin_reg;
        p_val_next   = p_val_reg;
        st_cmd.rd_en = 1'b0;
        st_cmd.wr_en = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    p_val_next = '0;
                    if (s_tuser[0] == REQ_READ)
                    begin
                        state_next = S_RD_ISS;
                    end
                    else if (en == '0)
                    begin
                        // checked ahead of the range test
                        p_stat_next = ST_NO_METRIC;
                        p_bin_next  = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_OFS;
            end
            S_OFS:
            begin
                neg_next   = offset[PROD_W-1];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    if (idx_out)
                    begin
                        p_stat_next = ST_RANGE;
                        p_bin_next  = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        p_stat_next = ST_OK;
                        p_bin_next  = div_res.quotient[RBIN_W-1:0];
                        bin_next    = div_res.quotient;
                        met_next    = '0;
                        state_next  = S_UPD_RD;
                    end
                end
            end
            S_UPD_RD:
            begin
                if (en[met_reg])
                begin
                    st_cmd.rd_en = 1'b1;
                    state_next   = S_UPD_WR;
                end
                else if (last_met)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    met_next = met_reg + RMET_W'(1);
                end
            end
            S_UPD_WR:
            begin
                st_cmd.wr_en = 1'b1;
                if (last_met)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    met_next   = met_reg + RMET_W'(1);
                    state_next = S_UPD_RD;
                end
            end
            S_RD_ISS:
            begin
                p_bin_next = rbin_reg;
                if (rd_ok)
                begin
                    st_cmd.rd_en = 1'b1;
                    state_next   = S_RD_DATA;
                end
                else
                begin
                    p_stat_next = ST_RANGE;
                    state_next  = S_DONE;
                end
            end
            S_RD_DATA:
            begin
                p_stat_next = ST_OK;
                p_val_next  = rd_wide[VALUE_W-1:0];
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_sec_reg <= '0;
            start_us_reg  <= '0;
            bin_width_reg <= WIDTH_W'(USEC_PER_SEC);
            bins_use_reg  <= BINS_W'(1024);
            metric_en_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_SECONDS: start_sec_reg <= cfg_data[SEC_W-1:0];
                CFG_START_MICROS:  start_us_reg  <= cfg_data[USEC_W-1:0];
                CFG_BIN_WIDTH:     bin_width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_BINS_IN_USE:   bins_use_reg  <= cfg_data[BINS_W-1:0];
                CFG_METRIC_ENABLE: metric_en_reg <= cfg_data[MEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_s_reg  <= s_tdata[31:0];
            ts_u_reg  <= s_tdata[51:32];
            len_reg   <= s_tdata[67:52];
            flags_reg <= s_tdata[75:68];
            rbin_reg  <= s_tdata[85:76];
            rmet_reg  <= s_tdata[88:86];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= sec_us;
        end
        neg_reg    <= neg_next;
        bin_reg    <= bin_next;
        met_reg    <= met_next;
        p_stat_reg <= p_stat_next;
        p_bin_reg  <= p_bin_next;
        p_val_reg  <= p_val_next;
        if (out_load)
        begin
            o_stat_reg <= p_stat_reg;
            o_bin_reg  <= p_bin_reg;
            o_val_reg  <= p_val_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - STAT_W - RBIN_W - VALUE_W){1'b0}},
                       o_val_reg, o_bin_reg, o_stat_reg};

    tbpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .dividend (magnitude),
        .divisor  (bin_width_reg),
        .res      (div_res)
    );

    tbpm_store #(
        .NUM_BINS    (NUM_BINS),
        .NUM_METRICS (NUM_METRICS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (st_cmd),
        .addr    (st_addr),
        .amount  (st_amount),
        .rd_data (st_rd_data),
        .stat    (st_stat)
    );

endmodule
`default_nettype wire
